FILE: rtl/lrtc_pkg.sv
// Types and constants shared by the LRU tile cache policy unit and its cells.
package lrtc_pkg;

    localparam int TAG_W  = 36;
    localparam int SLOT_W = 3;

    typedef logic [TAG_W-1:0] tag_t;

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_FILLED  = 2'd1,
        ST_FAILED  = 2'd2,
        ST_FLUSHED = 2'd3
    } status_t;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] tile_x;
        logic signed [15:0] tile_y;
        logic        [3:0]  tile_lod;
        logic               fill_ok;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic               evict_valid;
        logic signed [15:0] evict_x;
        logic signed [15:0] evict_y;
        logic        [3:0]  evict_lod;
    } rsp_t;

    // Accumulated along the cell row during lookup
    typedef struct packed {
        logic hit;
        logic vic_valid;
        tag_t vic_tag;
    } chain_t;

    // Update broadcast to all cells at the end of lookup
    typedef struct packed {
        logic touch;
        logic fill;
        logic flush;
        tag_t tag;
    } upd_t;

endpackage

FILE: rtl/lru_tile_cache_policy_unit.sv
// Top level of the LRU tile cache policy unit: request control and the row of directory cells.
//
// Fully associative LRU directory for tile ids {x, y, lod}. A request word is
// taken on a clock edge where start is high and busy is low. Busy is then high
// while the id is compared across the whole row of entry cells and the recency
// ranks, tags and valid bits are updated; the result word appears on result
// with done high in the following cycle, for that one cycle only, and must be
// captured then. A new request may be issued in the same cycle the result is
// shown; no new request is taken while busy is high.
module lru_tile_cache_policy_unit
    import lrtc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg;
    rsp_t   rsp_reg, rsp_next;
    logic   done_reg;

    tag_t             lookup_tag;
    chain_t           link      [0:CACHE_ENTRIES];
    logic [IDX_W-1:0] hit_idx   [0:CACHE_ENTRIES];
    logic [IDX_W-1:0] hit_rank  [0:CACHE_ENTRIES];
    logic [IDX_W-1:0] vic_idx   [0:CACHE_ENTRIES];

    upd_t             upd;
    logic [IDX_W-1:0] upd_slot;
    logic [IDX_W-1:0] upd_rank;

    assign lookup_tag = {req_reg.tile_x, req_reg.tile_y, req_reg.tile_lod};

    assign link[0]     = '0;
    assign hit_idx[0]  = '0;
    assign hit_rank[0] = '0;
    assign vic_idx[0]  = '0;

    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cell
        lrtc_cell #(
            .N       (CACHE_ENTRIES),
            .CELL_ID (i),
            .IDX_W   (IDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .lookup_tag   (lookup_tag),
            .chain_in     (link[i]),
            .hit_idx_in   (hit_idx[i]),
            .hit_rank_in  (hit_rank[i]),
            .vic_idx_in   (vic_idx[i]),
            .chain_out    (link[i+1]),
            .hit_idx_out  (hit_idx[i+1]),
            .hit_rank_out (hit_rank[i+1]),
            .vic_idx_out  (vic_idx[i+1]),
            .upd          (upd),
            .upd_slot     (upd_slot),
            .upd_rank     (upd_rank)
        );
    end

    always_comb
    begin
        upd      = '0;
        upd_slot = '0;
        upd_rank = '0;
        rsp_next = '0;
        upd.tag  = lookup_tag;
        if (req_reg.req_type == REQ_FLUSH)
        begin
            upd.flush       = 1'b1;
            rsp_next.status = ST_FLUSHED;
        end
        else if (link[CACHE_ENTRIES].hit)
        begin
            upd.touch       = 1'b1;
            upd_slot        = hit_idx[CACHE_ENTRIES];
            upd_rank        = hit_rank[CACHE_ENTRIES];
            rsp_next.status = ST_HIT;
            rsp_next.slot   = SLOT_W'(hit_idx[CACHE_ENTRIES]);
        end
        else if (!req_reg.fill_ok)
        begin
            rsp_next.status = ST_FAILED;
        end
        else
        begin
            upd.touch            = 1'b1;
            upd.fill             = 1'b1;
            upd_slot             = vic_idx[CACHE_ENTRIES];
            rsp_next.status      = ST_FILLED;
            rsp_next.slot        = SLOT_W'(vic_idx[CACHE_ENTRIES]);
            rsp_next.evict_valid = link[CACHE_ENTRIES].vic_valid;
            rsp_next.evict_x     = link[CACHE_ENTRIES].vic_tag[35:20];
            rsp_next.evict_y     = link[CACHE_ENTRIES].vic_tag[19:4];
            rsp_next.evict_lod   = link[CACHE_ENTRIES].vic_tag[3:0];
        end
        if (state_reg != S_LOOKUP)
        begin
            upd = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_LOOKUP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (state_reg == S_LOOKUP)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy   = (state_reg == S_LOOKUP);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

FILE: rtl/lrtc_cell.sv
// One directory entry: tag, valid bit and recency rank, plus its stage of the lookup chain.
module lrtc_cell
    import lrtc_pkg::*;
#(
    parameter int N       = 8,
    parameter int CELL_ID = 0,
    parameter int IDX_W   = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tag_t             lookup_tag,
    input  chain_t           chain_in,
    input  logic [IDX_W-1:0] hit_idx_in,
    input  logic [IDX_W-1:0] hit_rank_in,
    input  logic [IDX_W-1:0] vic_idx_in,
    output chain_t           chain_out,
    output logic [IDX_W-1:0] hit_idx_out,
    output logic [IDX_W-1:0] hit_rank_out,
    output logic [IDX_W-1:0] vic_idx_out,
    input  upd_t             upd,
    input  logic [IDX_W-1:0] upd_slot,
    input  logic [IDX_W-1:0] upd_rank
);

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_ID);
    localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(N - 1);

    tag_t             tag_reg,   tag_next;
    logic             valid_reg, valid_next;
    logic [IDX_W-1:0] rank_reg,  rank_next;

    logic hit_me;
    logic vic_me;

    assign hit_me = valid_reg && (tag_reg == lookup_tag);
    assign vic_me = (rank_reg == '0);

    always_comb
    begin
        chain_out.hit       = chain_in.hit | hit_me;
        chain_out.vic_valid = chain_in.vic_valid | (vic_me & valid_reg);
        chain_out.vic_tag   = chain_in.vic_tag | ((vic_me && valid_reg) ? tag_reg : '0);
        hit_idx_out         = hit_idx_in  | (hit_me ? MY_IDX : '0);
        hit_rank_out        = hit_rank_in | (hit_me ? rank_reg : '0);
        vic_idx_out         = vic_idx_in  | (vic_me ? MY_IDX : '0);
    end

    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.flush)
        begin
            valid_next = 1'b0;
        end
        else if (upd.touch)
        begin
            if (upd_slot == MY_IDX)
            begin
                rank_next = TOP_RANK;
                if (upd.fill)
                begin
                    tag_next   = upd.tag;
                    valid_next = 1'b1;
                end
            end
            else if (rank_reg > upd_rank)
            begin
                rank_next = rank_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= MY_IDX;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule
